/* sv/page_free_list_allocator_defines.svh */
// Assertion macros for the page allocator RTL.
`ifndef PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFLA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfla assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFLA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfla assertion failed");

`endif

/* sv/pfla_pkg.sv */
// Shared types and constants of the page free-list allocator.
`default_nettype none
package pfla_pkg;
	localparam int ADDR_W    = 40;
	localparam int BYTES_W   = 28;
	localparam int CFG_IDX_W = 1;

	localparam logic [ADDR_W-1:0] MEM_LOW_RST  = 40'd0;
	localparam logic [ADDR_W-1:0] MEM_HIGH_RST = 40'd134217728;

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_COUNT = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_BADADDR = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEM_LOW  = 1'b0,
		REG_MEM_HIGH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stack_flags_t;
endpackage
`default_nettype wire

/* sv/page_free_list_allocator.sv */
// Top level of the page free-list allocator.
// Usage:
//   Requests enter on in_valid/in_ready with func and page_address. func
//   allocates a page, frees a page or reads the free byte count; every
//   request yields exactly one result item on out_valid/out_ready with
//   status, granted_address and free_bytes.
//   mem_low and mem_high are written through cfg_wen/cfg_index/cfg_wdata
//   while no request is in flight; the user keeps to this, the block does not enforce it.
// Path: an accepted request is held in the input stage and is then written
//   to the result register when that register is empty or being drained;
//   out_valid and the result fields are driven from the result register.
// Throughput: one request per cycle while out_ready is high. The stack top
//   lives in a register and the entry beneath it is read from the memory
//   in advance, so a pop or push every cycle needs only one memory read port.
// Reset: the page count clears to zero and the limit registers take their
//   reset values; stack memory contents are not cleared and need none.
// Stall: when a result is held and out_ready is low, the result register
//   holds, the input stage fills, and in_ready drops until the result is taken.
`default_nettype none
module page_free_list_allocator #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [pfla_pkg::ADDR_W-1:0]     page_address,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [pfla_pkg::ADDR_W-1:0]     granted_address,
	output logic [pfla_pkg::BYTES_W-1:0]    free_bytes,
	// configuration write port
	input  logic                            cfg_wen,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfla_pkg::ADDR_W-1:0]     cfg_wdata
);
	import pfla_pkg::*;

	`include "page_free_list_allocator_defines.svh"

	localparam int PB_BITS = $clog2(PAGE_BYTES);
	localparam int PN_W    = ADDR_W - PB_BITS;
	localparam int CW      = $clog2(MAX_PAGES + 1);

	// limit registers
	logic [ADDR_W-1:0] mem_low_q;
	logic [ADDR_W-1:0] mem_high_q;

	// input stage
	logic              v_s1;
	logic [1:0]        func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              fire_s1;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] granted_q;
	logic [BYTES_W-1:0] bytes_q;

	stack_op_t         op;
	stack_flags_t      flags;
	status_t           status_c;
	logic [PN_W-1:0]   top_page;
	logic [CW-1:0]     count;
	logic [CW-1:0]     count_next;
	logic [63:0]       bytes_wide;

	// stage 1 advances when the result register is empty or being drained
	assign fire_s1  = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_low_q  <= MEM_LOW_RST;
			mem_high_q <= MEM_HIGH_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MEM_LOW:  mem_low_q  <= cfg_wdata;
				REG_MEM_HIGH: mem_high_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			addr_s1 <= page_address;
		end
	end

	pfla_check #(
		.PB_BITS(PB_BITS)
	) u_check (
		.func        (func_s1),
		.page_address(addr_s1),
		.mem_low     (mem_low_q),
		.mem_high    (mem_high_q),
		.flags       (flags),
		.op          (op),
		.status      (status_c)
	);

	pfla_stack #(
		.MAX_PAGES(MAX_PAGES),
		.PN_W     (PN_W),
		.CW       (CW)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (fire_s1),
		.op        (op),
		.push_page (addr_s1[ADDR_W-1:PB_BITS]),
		.top_page  (top_page),
		.count     (count),
		.count_next(count_next),
		.flags     (flags)
	);

	// free bytes after the operation, wrapped to the field width
	assign bytes_wide = 64'(count_next) << PB_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_q  <= status_c;
			granted_q <= op.pop ? {top_page, {PB_BITS{1'b0}}} : '0;
			bytes_q   <= bytes_wide[BYTES_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign free_bytes      = bytes_q;

	`PFLA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count <= CW'(MAX_PAGES))
	`PFLA_ASSERT_NOW(a_grant_only_ok, clk, arst_n, out_valid_q && (status_q != ST_OK),
		granted_q == '0)
	`PFLA_ASSERT_NEXT(a_pop_count, clk, arst_n, fire_s1 && op.pop,
		count == $past(count) - CW'(1))
	`PFLA_ASSERT_NEXT(a_idle_count, clk, arst_n, !fire_s1, $stable(count))
endmodule
`default_nettype wire

/* sv/pfla_check.sv */
// Request decode: address checks and stack operation selection.
`default_nettype none
module pfla_check #(
	parameter int PB_BITS = 12
) (
	input  logic [1:0]                 func,
	input  logic [pfla_pkg::ADDR_W-1:0] page_address,
	input  logic [pfla_pkg::ADDR_W-1:0] mem_low,
	input  logic [pfla_pkg::ADDR_W-1:0] mem_high,
	input  pfla_pkg::stack_flags_t     flags,
	output pfla_pkg::stack_op_t        op,
	output pfla_pkg::status_t          status
);
	import pfla_pkg::*;

	logic aligned;
	logic in_range;

	assign aligned  = (page_address[PB_BITS-1:0] == '0);
	assign in_range = (page_address >= mem_low) && (page_address < mem_high);

	always_comb begin
		op     = '0;
		status = ST_OK;
		case (func)
			FN_ALLOC: begin
				if (flags.empty) begin
					status = ST_EMPTY;
				end else begin
					op.pop = 1'b1;
				end
			end
			FN_FREE: begin
				// address check wins over the full check
				if (!aligned || !in_range) begin
					status = ST_BADADDR;
				end else if (flags.full) begin
					status = ST_FULL;
				end else begin
					op.push = 1'b1;
				end
			end
			default: begin
				// count and the unused code: report only
			end
		endcase
	end
endmodule
`default_nettype wire

/* sv/pfla_stack.sv */
// LIFO of free page numbers: top register, count, and backing memory.
`default_nettype none
module pfla_stack #(
	parameter int MAX_PAGES = 32768,
	parameter int PN_W      = 28,
	parameter int CW        = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  pfla_pkg::stack_op_t    op,
	input  logic [PN_W-1:0]        push_page,
	output logic [PN_W-1:0]        top_page,
	output logic [CW-1:0]          count,
	output logic [CW-1:0]          count_next,
	output pfla_pkg::stack_flags_t flags
);
	import pfla_pkg::*;

	localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	logic [PN_W-1:0] mem [MAX_PAGES];
	logic [PN_W-1:0] rd_q;      // entry at count-2, refreshed each cycle
	logic [PN_W-1:0] top_q;     // entry at count-1
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_addr;
	logic            do_push;
	logic            do_pop;

	assign do_push = en && op.push;
	assign do_pop  = en && op.pop;

	always_comb begin
		count_next = count_q;
		if (do_push) begin
			count_next = count_q + CW'(1);
		end else if (do_pop) begin
			count_next = count_q - CW'(1);
		end
	end

	// Read the entry below the next top so a pop can refill top_q next cycle.
	assign rd_addr = count_next - CW'(2);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[count_q[IW-1:0]] <= push_page;
		end
		rd_q <= mem[rd_addr[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			top_q <= push_page;
		end else if (do_pop) begin
			top_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign top_page    = top_q;
	assign count       = count_q;
	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q >= CW'(MAX_PAGES));
endmodule
`default_nettype wire
